@@ rtl/osd_pkg.sv @@
`default_nettype none
package osd_pkg;

  localparam int WINDOW     = 100;
  localparam int POS_BITS   = 20;
  localparam int THR_BITS   = 16;
  localparam int SKIP_BITS  = 20;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = (THR_BITS > SKIP_BITS) ? THR_BITS : SKIP_BITS;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam int SQ_W   = 2 * POS_BITS;
  localparam int THR2_W = 2 * THR_BITS;
  localparam int SUM_W  = ((SQ_W + 1) > THR2_W) ? (SQ_W + 1) : THR2_W;
  localparam int CMPX_W = (POS_BITS > SKIP_BITS) ? POS_BITS : SKIP_BITS;
  localparam int RAM_W  = 2 * POS_BITS;

  // With a very short window a later sample would read a slot before the
  // earlier write to it has landed, so only one sample is then in flight.
  localparam bit PIPE_SERIAL = (WINDOW < 4);

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_MOVE_THRESHOLD,
    REG_ORIGIN_SKIP
  } cfg_reg_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] pos_x;
    logic signed [POS_BITS-1:0] pos_y;
  } sample_t;

  typedef struct packed {
    logic return_request;
    logic compared;
    logic skipped;
  } result_t;

  typedef struct packed {
    logic            skip;
    sample_t         pos;
    logic [SQ_W-1:0] sx;
    logic [SQ_W-1:0] sy;
  } sq_item_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    sample_t           data;
  } win_wr_t;

endpackage
`default_nettype wire

@@ rtl/osd_ram.sv @@
`default_nettype none
module osd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]  wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output      logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

@@ rtl/osd_front.sv @@
`default_nettype none
module osd_front (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               advance,
  input  wire logic                               accept,
  input  wire osd_pkg::sample_t                   in_data,
  input  wire logic signed [osd_pkg::SKIP_BITS-1:0] origin_skip,
  input  wire logic                               window_clear,
  input  wire osd_pkg::sample_t                   rd_data,
  output      logic                               rd_en,
  output      logic [osd_pkg::SLOT_W-1:0]         rd_addr,
  output      logic                               sq_valid,
  output      osd_pkg::sq_item_t                  sq_item,
  output      logic                               busy
);
  import osd_pkg::*;

  logic signed [CMPX_W-1:0] xe;
  logic signed [CMPX_W-1:0] ye;
  logic signed [CMPX_W-1:0] oe;
  logic                     skip0;
  logic [SLOT_W-1:0]        front_slot;
  logic [SLOT_W-1:0]        front_slot_next;
  logic [1:0]               live_cnt;

  logic                     s1_valid;
  logic                     s1_skip;
  sample_t                  s1_pos;
  logic signed [POS_BITS:0] ddx;
  logic signed [POS_BITS:0] ddy;
  logic signed [POS_BITS:0] adx;
  logic signed [POS_BITS:0] ady;

  logic                     s2_valid;
  logic                     s2_skip;
  sample_t                  s2_pos;
  logic [POS_BITS-1:0]      s2_dx;
  logic [POS_BITS-1:0]      s2_dy;

  always_comb begin
    xe    = CMPX_W'(in_data.pos_x);
    ye    = CMPX_W'(in_data.pos_y);
    oe    = CMPX_W'(origin_skip);
    skip0 = (xe < oe) && (ye < oe);
  end

  assign rd_en   = accept && !skip0;
  assign rd_addr = front_slot;

  // The read pointer runs ahead of the committed write slot. When the window
  // is emptied it restarts behind the samples that are still in flight.
  always_comb begin
    live_cnt = 2'(s1_valid && !s1_skip) + 2'(s2_valid && !s2_skip) + 2'(rd_en);
    front_slot_next = front_slot;
    if (advance && window_clear) begin
      front_slot_next = SLOT_W'(live_cnt);
    end else if (rd_en) begin
      front_slot_next = (front_slot == SLOT_W'(WINDOW - 1)) ? '0 : front_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_slot <= '0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
    end else begin
      front_slot <= front_slot_next;
      if (advance) begin
        s1_valid <= accept;
        s2_valid <= s1_valid;
      end
    end
  end

  always_comb begin
    ddx = (POS_BITS + 1)'(s1_pos.pos_x) - (POS_BITS + 1)'(rd_data.pos_x);
    ddy = (POS_BITS + 1)'(s1_pos.pos_y) - (POS_BITS + 1)'(rd_data.pos_y);
    adx = ddx[POS_BITS] ? -ddx : ddx;
    ady = ddy[POS_BITS] ? -ddy : ddy;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_skip <= skip0;
      s1_pos  <= in_data;
      s2_skip <= s1_skip;
      s2_pos  <= s1_pos;
      s2_dx   <= adx[POS_BITS-1:0];
      s2_dy   <= ady[POS_BITS-1:0];
    end
  end

  always_comb begin
    sq_item.skip = s2_skip;
    sq_item.pos  = s2_pos;
    sq_item.sx   = SQ_W'(s2_dx) * SQ_W'(s2_dx);
    sq_item.sy   = SQ_W'(s2_dy) * SQ_W'(s2_dy);
  end

  assign sq_valid = s2_valid;
  assign busy     = s1_valid || s2_valid;

endmodule
`default_nettype wire

@@ rtl/osd_judge.sv @@
`default_nettype none
module osd_judge (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         advance,
  input  wire logic                         sq_valid,
  input  wire osd_pkg::sq_item_t            sq_item,
  input  wire logic [osd_pkg::THR_BITS-1:0] move_threshold,
  output      osd_pkg::win_wr_t             win_wr,
  output      logic                         window_clear,
  output      logic                         busy,
  output      logic                         out_valid,
  output      osd_pkg::result_t             out_data
);
  import osd_pkg::*;

  logic [THR2_W-1:0] thr2;
  logic              s3_valid;
  sq_item_t          s3;
  logic [SUM_W-1:0]  sum;
  logic              moved;
  logic              full;
  logic              commit;
  result_t           result;

  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] write_slot_next;
  logic [FILL_W-1:0] fill_count;
  logic [FILL_W-1:0] fill_count_next;

  always_ff @(posedge clk) begin
    thr2 <= THR2_W'(move_threshold) * THR2_W'(move_threshold);
    if (advance) begin
      s3 <= sq_item;
    end
  end

  always_comb begin
    sum    = SUM_W'(s3.sx) + SUM_W'(s3.sy);
    moved  = sum > SUM_W'(thr2);
    full   = (fill_count == FILL_W'(WINDOW));
    commit = advance && s3_valid;

    win_wr.en    = commit && !s3.skip && (!full || moved);
    win_wr.addr  = write_slot;
    win_wr.data  = s3.pos;
    window_clear = commit && !s3.skip && full && !moved;

    result.skipped        = s3.skip;
    result.compared       = !s3.skip && full;
    result.return_request = !s3.skip && full && !moved;
  end

  always_comb begin
    write_slot_next = write_slot;
    fill_count_next = fill_count;
    if (window_clear) begin
      write_slot_next = '0;
      fill_count_next = '0;
    end else if (win_wr.en) begin
      write_slot_next = (write_slot == SLOT_W'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
      if (!full) begin
        fill_count_next = fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid   <= 1'b0;
      out_valid  <= 1'b0;
      write_slot <= '0;
      fill_count <= '0;
    end else begin
      write_slot <= write_slot_next;
      fill_count <= fill_count_next;
      if (advance) begin
        s3_valid  <= sq_valid;
        out_valid <= s3_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_data <= result;
    end
  end

  assign busy = s3_valid;

endmodule
`default_nettype wire

@@ rtl/odometry_stall_detector.sv @@
`default_nettype none
// Channel  Direction  Handshake             Payload
// in       sink       in_valid / in_ready   in_data  (pos_x, pos_y)
// out      source     out_valid / out_ready out_data (return_request, compared, skipped)
// cfg      sink       cfg_we                cfg_addr, cfg_data
//
// One sample per cycle while the output is not stalled; a result reaches the
// output register through the window RAM read, the squaring stage and the
// compare-and-commit stage. For a window shorter than four entries only one
// sample is in flight: a new one is taken once the last has left that stage.
// Reset is synchronous; the window memory is not cleared, the fill count
// guards it. A stalled output freezes the whole pipeline.
module odometry_stall_detector (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire osd_pkg::sample_t               in_data,
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      osd_pkg::result_t               out_data,
  input  wire logic                           cfg_we,
  input  wire logic [osd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [osd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import osd_pkg::*;

  logic [THR_BITS-1:0]         move_threshold;
  logic signed [SKIP_BITS-1:0] origin_skip;

  logic        advance;
  logic        accept;
  logic        front_busy;
  logic        judge_busy;
  logic        rd_en;
  logic [SLOT_W-1:0] rd_addr;
  logic [RAM_W-1:0]  rd_raw;
  sample_t     rd_sample;
  logic        sq_valid;
  sq_item_t    sq_item;
  win_wr_t     win_wr;
  logic        window_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      move_threshold <= THR_BITS'(100);
      origin_skip    <= SKIP_BITS'(80);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_addr))
        REG_MOVE_THRESHOLD: move_threshold <= cfg_data[THR_BITS-1:0];
        REG_ORIGIN_SKIP:    origin_skip    <= cfg_data[SKIP_BITS-1:0];
        default:            ;
      endcase
    end
  end

  assign advance  = !out_valid || out_ready;
  assign in_ready = advance && !(PIPE_SERIAL && (front_busy || judge_busy));
  assign accept   = in_valid && in_ready;

  assign rd_sample = sample_t'(rd_raw);

  osd_ram #(
    .WIDTH(RAM_W),
    .DEPTH(WINDOW)
  ) u_window (
    .clk    (clk),
    .wr_en  (win_wr.en),
    .wr_addr(win_wr.addr),
    .wr_data(RAM_W'(win_wr.data)),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_raw)
  );

  osd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .accept      (accept),
    .in_data     (in_data),
    .origin_skip (origin_skip),
    .window_clear(window_clear),
    .rd_data     (rd_sample),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .sq_valid    (sq_valid),
    .sq_item     (sq_item),
    .busy        (front_busy)
  );

  osd_judge u_judge (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .sq_valid      (sq_valid),
    .sq_item       (sq_item),
    .move_threshold(move_threshold),
    .win_wr        (win_wr),
    .window_clear  (window_clear),
    .busy          (judge_busy),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

  // Emptying the window and storing a sample exclude each other.
  a_clear_no_write: assert property (@(posedge clk) disable iff (rst)
    window_clear |-> !win_wr.en)
    else $error("window cleared while a sample is being stored");

  // A return request comes only from a comparison, and a skipped sample is
  // never compared.
  a_result_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_data.return_request || out_data.compared) &&
                  !(out_data.skipped && out_data.compared))
    else $error("inconsistent result flags");

  // The pipeline only moves on when the output register can take a result.
  a_commit_needs_room: assert property (@(posedge clk) disable iff (rst)
    (win_wr.en || window_clear) |-> advance)
    else $error("state committed while the output is stalled");

endmodule
`default_nettype wire

@@ verif/osd_checker.sv @@
`timescale 1ns / 100ps
module osd_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  osd_pkg::sample_t               in_data,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  osd_pkg::result_t               out_data,
  input  logic                           cfg_we,
  input  logic [osd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [osd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatches,
  output int                             outstanding
);
  import osd_pkg::*;

  localparam int THR_RESET  = 100;
  localparam int SKIP_RESET = 80;

  // Positions of the last WINDOW kept samples, stored as a ring.
  int      trail_x [WINDOW];
  int      trail_y [WINDOW];
  int      oldest_slot;
  int      kept_count;
  int      move_thr;
  int      skip_limit;
  result_t pending_verdicts [$];

  function automatic result_t judge_sample(sample_t s);
    result_t r;
    int      x;
    int      y;
    longint  dx;
    longint  dy;
    longint  dist2;
    longint  thr2;
    r = '0;
    x = int'(signed'(s.pos_x));
    y = int'(signed'(s.pos_y));
    if (x < skip_limit && y < skip_limit) begin
      r.skipped = 1'b1;
    end else if (kept_count < WINDOW) begin
      trail_x[oldest_slot] = x;
      trail_y[oldest_slot] = y;
      kept_count++;
      oldest_slot = (oldest_slot + 1 == WINDOW) ? 0 : oldest_slot + 1;
    end else begin
      dx    = longint'(x) - longint'(trail_x[oldest_slot]);
      dy    = longint'(y) - longint'(trail_y[oldest_slot]);
      dist2 = dx * dx + dy * dy;
      thr2  = longint'(move_thr) * longint'(move_thr);
      r.compared = 1'b1;
      if (dist2 > thr2) begin
        trail_x[oldest_slot] = x;
        trail_y[oldest_slot] = y;
        oldest_slot = (oldest_slot + 1 == WINDOW) ? 0 : oldest_slot + 1;
      end else begin
        // A stall empties the window, the current sample included.
        r.return_request = 1'b1;
        oldest_slot = 0;
        kept_count = 0;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      oldest_slot = 0;
      kept_count = 0;
      move_thr = THR_RESET;
      skip_limit = SKIP_RESET;
      pending_verdicts.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_MOVE_THRESHOLD) begin
          move_thr = int'(cfg_data[THR_BITS-1:0]);
        end else if (cfg_addr == REG_ORIGIN_SKIP) begin
          skip_limit = int'(signed'(cfg_data[SKIP_BITS-1:0]));
        end
      end
      if (in_valid && in_ready) begin
        pending_verdicts.push_back(judge_sample(in_data));
      end
      if (out_valid && out_ready) begin
        if (pending_verdicts.size() == 0) begin
          $error("result transaction with no sample waiting for it");
          mismatches++;
        end else begin
          want = pending_verdicts.pop_front();
          if (out_data.return_request !== want.return_request) begin
            $error("return_request: expected %0b, got %0b",
                   want.return_request, out_data.return_request);
            mismatches++;
          end
          if (out_data.compared !== want.compared) begin
            $error("compared: expected %0b, got %0b", want.compared, out_data.compared);
            mismatches++;
          end
          if (out_data.skipped !== want.skipped) begin
            $error("skipped: expected %0b, got %0b", want.skipped, out_data.skipped);
            mismatches++;
          end
        end
      end
    end
    outstanding <= pending_verdicts.size();
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import osd_pkg::*;

  localparam int POS_MIN     = -(2 ** (POS_BITS - 1));
  localparam int POS_MAX     = 2 ** (POS_BITS - 1) - 1;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;

  typedef enum {SEG_STILL, SEG_MOVING, SEG_NOISE, SEG_NEAR_ORIGIN} segment_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  sample_t               in_data   = '0;
  logic                  out_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_ready;
  logic                  out_valid;
  result_t               out_data;
  int                    mismatches;
  int                    outstanding;
  int                    cycle_count = 0;

  // Stimulus shaping only: the configuration currently programmed.
  int thr_now  = 100;
  int skip_now = 80;
  int base_x   = 0;
  int base_y   = 0;
  int vel_x    = 0;
  int vel_y    = 0;
  bit steady   = 1'b0;
  bit hold_req = 1'b0;

  always #5 clk = ~clk;

  odometry_stall_detector dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

  osd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= 20);
      end
    end
  end

  function automatic int clamp_pos(longint v);
    if (v < POS_MIN) return POS_MIN;
    if (v > POS_MAX) return POS_MAX;
    return int'(v);
  endfunction

  function automatic int spread(int j);
    return int'($urandom_range(2 * j)) - j;
  endfunction

  function automatic int any_pos();
    return int'($urandom_range(POS_MAX - POS_MIN)) + POS_MIN;
  endfunction

  function automatic int below_skip();
    case ($urandom_range(3))
      0:       return POS_MIN;
      1:       return skip_now - 1;
      default: return POS_MIN + int'($urandom_range(skip_now - 1 - POS_MIN));
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic push_sample(int x, int y);
    if (!steady && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.pos_x <= POS_BITS'(clamp_pos(x));
    in_data.pos_y <= POS_BITS'(clamp_pos(y));
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] word);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= word;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int items, logic [CFG_DATA_W-1:0] thr_word,
                           logic [CFG_DATA_W-1:0] skip_word, int hold_at);
    segment_t kind;
    int       seg_len;
    int       lo;
    int       tmp;
    int       x;
    int       y;
    int       n;
    write_reg(REG_MOVE_THRESHOLD, thr_word);
    write_reg(REG_ORIGIN_SKIP, skip_word);
    thr_now  = int'(thr_word[THR_BITS-1:0]);
    skip_now = int'(signed'(skip_word[SKIP_BITS-1:0]));
    n = 0;
    while (n < items) begin
      tmp = $urandom_range(99);
      kind = (tmp < 35) ? SEG_STILL : (tmp < 70) ? SEG_MOVING :
             (tmp < 85) ? SEG_NOISE : SEG_NEAR_ORIGIN;
      if (kind == SEG_NEAR_ORIGIN && skip_now == POS_MIN) kind = SEG_NOISE;
      seg_len = (kind == SEG_STILL || kind == SEG_MOVING) ?
                $urandom_range(40, 160) : $urandom_range(5, 30);
      if (kind == SEG_STILL || kind == SEG_MOVING) begin
        // One coordinate at or above the skip limit keeps the track visible.
        lo = (skip_now > POS_MIN) ? skip_now : POS_MIN;
        base_x = lo + int'($urandom_range(POS_MAX - lo));
        base_y = any_pos();
        if ($urandom_range(1)) begin
          tmp = base_x;
          base_x = base_y;
          base_y = tmp;
        end
        vel_x = spread(thr_now / 50 + 2);
        vel_y = spread(thr_now / 50 + 2);
      end
      for (int k = 0; k < seg_len && n < items; k++) begin
        case (kind)
          SEG_STILL: begin
            x = base_x;
            y = base_y;
            case ($urandom_range(9))
              0:       x = base_x + thr_now;
              1:       y = base_y - thr_now - 1;
              2:       x = base_x - thr_now;
              3, 4, 5: ;
              default: begin
                x = base_x + spread(thr_now / 4);
                y = base_y + spread(thr_now / 4);
              end
            endcase
          end
          SEG_MOVING: begin
            base_x = clamp_pos(longint'(base_x) + vel_x + spread(1));
            base_y = clamp_pos(longint'(base_y) + vel_y + spread(1));
            x = base_x;
            y = base_y;
          end
          SEG_NOISE: begin
            x = ($urandom_range(3) == 0) ? ($urandom_range(1) ? POS_MAX : POS_MIN) : any_pos();
            y = ($urandom_range(3) == 0) ? ($urandom_range(1) ? POS_MAX : POS_MIN) : any_pos();
          end
          default: begin
            x = below_skip();
            y = below_skip();
            // Now and then one coordinate sits exactly on the limit.
            if ($urandom_range(4) == 0) begin
              if ($urandom_range(1)) x = skip_now;
              else y = skip_now;
            end
          end
        endcase
        push_sample(x, y);
        n++;
        if (n == hold_at) hold_req = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed samples under the reset settings: extremes and both sides of
    // the near-origin limit.
    push_sample(POS_MIN, POS_MIN);
    push_sample(79, 79);
    push_sample(79, 80);
    push_sample(80, 79);
    push_sample(80, 80);
    push_sample(0, 0);
    push_sample(-1, -1);
    push_sample(79, POS_MIN);
    push_sample(POS_MAX, POS_MAX);
    push_sample(POS_MIN, POS_MAX);
    push_sample(POS_MAX, POS_MIN);
    push_sample(int'(signed'(20'h55555)), int'(signed'(20'hAAAAA)));
    push_sample(int'(signed'(20'hAAAAA)), int'(signed'(20'h55555)));

    // Zero threshold and lowest skip limit, with no idling and one long
    // hold-off on the result side so that the pipeline backs up.
    steady = 1'b1;
    run_phase(130, CFG_DATA_W'(0), CFG_DATA_W'(POS_MIN), 40);
    steady = 1'b0;
    // Highest threshold and skip limit; the spare bits of the threshold word are nonzero.
    run_phase(120, {4'hA, 16'hFFFF}, CFG_DATA_W'(POS_MAX), -1);
    run_phase(130, {4'h5, 16'd100}, CFG_DATA_W'(80), -1);
    run_phase(140, CFG_DATA_W'($urandom_range(2 ** CFG_DATA_W - 1)),
              CFG_DATA_W'(spread(2000)), -1);
    run_phase(150, {4'($urandom_range(15)), 16'($urandom_range(300))},
              CFG_DATA_W'(any_pos()), -1);

    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
